FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the card check checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lcc_pkg.sv
// ----------------------------------------------------------------------------
// lcc_pkg
// shared types, constants and helpers for the card number check
// ----------------------------------------------------------------------------
package lcc_pkg;

  localparam int IN_W          = 63;
  localparam int BITS_PER_STEP = 3;
  localparam int NUM_STEPS     = IN_W / BITS_PER_STEP;
  localparam int NUM_CELLS     = 19;
  localparam int GROUP_SIZE    = 4;
  localparam int NUM_GROUPS    = (NUM_CELLS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int COUNT_W       = 5;
  localparam int STEP_W        = $clog2(NUM_STEPS);
  localparam int MAX_DIGITS_DEF = 19;

  typedef logic [3:0]               digit_t;
  typedef logic [1:0]               class_t;
  typedef logic [COUNT_W-1:0]       count_t;
  typedef logic [BITS_PER_STEP-1:0] link_t;

  localparam class_t CLASS_INVALID = 2'd0;
  localparam class_t CLASS_FIFTEEN = 2'd1;
  localparam class_t CLASS_SIXTEEN = 2'd2;
  localparam class_t CLASS_FOUR    = 2'd3;

  localparam count_t LEN_THIRTEEN = 5'd13;
  localparam count_t LEN_FIFTEEN  = 5'd15;
  localparam count_t LEN_SIXTEEN  = 5'd16;

  // add two decimal digits modulo ten
  function automatic digit_t add10(input digit_t a, input digit_t b);
    logic [4:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 5'd10) begin
      s = s - 5'd10;
    end
    return s[3:0];
  endfunction

endpackage

FILE: hw/rtl/lcc_cell.sv
// ----------------------------------------------------------------------------
// lcc_cell
// one decimal digit of the binary to bcd chain, three bits shifted per cycle while step is high
// ----------------------------------------------------------------------------
module lcc_cell import lcc_pkg::*; (
  input  logic   clk,
  input  logic   clr,
  input  logic   step,
  input  link_t  bits_in,
  input  logic   dbl,
  input  logic   en,
  output link_t  bits_out,
  output digit_t dig,
  output digit_t term
);

  digit_t     dig_next;
  logic [4:0] twice;

  // add three when five or more, then shift, once per incoming bit
  always_comb begin
    dig_next = dig;
    bits_out = '0;
    for (int i = BITS_PER_STEP - 1; i >= 0; i--) begin
      if (dig_next >= 4'd5) begin
        dig_next = dig_next + 4'd3;
      end
      bits_out[i] = dig_next[3];
      dig_next    = {dig_next[2:0], bits_in[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      dig <= '0;
    end else if (step) begin
      dig <= dig_next;
    end
  end

  // luhn contribution of this digit position
  always_comb begin
    twice = {dig, 1'b0};
    if (!en) begin
      term = '0;
    end else if (dbl) begin
      term = (twice >= 5'd10) ? 4'(twice - 5'd9) : twice[3:0];
    end else begin
      term = dig;
    end
  end

endmodule

FILE: hw/rtl/lcc_fold.sv
// ----------------------------------------------------------------------------
// lcc_fold
// digit count, luhn sum and prefix class over the finished digit row
// ----------------------------------------------------------------------------
module lcc_fold import lcc_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                      clk,
  input  logic                      load,
  input  digit_t [NUM_CELLS-1:0]    digs,
  input  digit_t [NUM_CELLS-1:0]    terms,
  output class_t                    cls,
  output logic                      ok,
  output count_t                    cnt
);

  localparam count_t MAX_CNT = COUNT_W'(MAX_DIGITS);

  digit_t [NUM_GROUPS-1:0] part_next;
  digit_t [NUM_GROUPS-1:0] part;
  count_t                  raw_cnt_next;
  count_t                  raw_cnt;
  digit_t                  total;
  digit_t                  top;
  digit_t                  below;
  logic                    overflow;

  // first stage: group sums modulo ten and leading digit position
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      part_next[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < NUM_CELLS) begin
          part_next[g] = add10(part_next[g], terms[g * GROUP_SIZE + k]);
        end
      end
    end
    raw_cnt_next = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (digs[i] != '0) begin
        raw_cnt_next = COUNT_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      part    <= part_next;
      raw_cnt <= raw_cnt_next;
    end
  end

  // second stage: total, two leading digits, class
  always_comb begin
    total = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      total = add10(total, part[g]);
    end
    top   = '0;
    below = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (COUNT_W'(i + 1) == raw_cnt) begin
        top = digs[i];
      end
      if (COUNT_W'(i + 2) == raw_cnt) begin
        below = digs[i];
      end
    end
    overflow = raw_cnt > MAX_CNT;
    ok       = total == '0;
    cnt      = overflow ? MAX_CNT : raw_cnt;
    cls      = CLASS_INVALID;
    if (ok && !overflow) begin
      if (top == 4'd3 && (below == 4'd4 || below == 4'd7) && raw_cnt == LEN_FIFTEEN) begin
        cls = CLASS_FIFTEEN;
      end else if (top == 4'd5 && below >= 4'd1 && below <= 4'd5
                   && raw_cnt == LEN_SIXTEEN) begin
        cls = CLASS_SIXTEEN;
      end else if (top == 4'd4 && (raw_cnt == LEN_THIRTEEN || raw_cnt == LEN_SIXTEEN)) begin
        cls = CLASS_FOUR;
      end
    end
  end

endmodule

FILE: hw/rtl/luhn_card_number_check.sv
// ----------------------------------------------------------------------------
// luhn_card_number_check
// luhn mod-10 check and prefix class of a binary card number
//
//   channel  | valid / stall              | payload
//   ---------+----------------------------+----------------------------------
//   card     | card_valid / card_stall    | card_number
//   result   | result_valid / result_stall| card_class, luhn_ok, digit_count
//
// Each transaction is loaded, shifted through the digit cell row
// (three input bits per cycle into 19 bcd cells), summed in groups and
// classified into the output register.
// rst is synchronous; it clears the sequencer and the result valid flag.
// card_stall is high while a transaction is in progress; a stalled result
// waits in the output register and holds the block in its last cycle.
// ----------------------------------------------------------------------------
module luhn_card_number_check import lcc_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            card_valid,
  output logic            card_stall,
  input  logic [IN_W-1:0] card_number,
  output logic            result_valid,
  input  logic            result_stall,
  output class_t          card_class,
  output logic            luhn_ok,
  output count_t          digit_count
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SUM  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]              state;
  logic [STEP_W-1:0]       step_cnt;
  logic [IN_W-1:0]         sreg;
  logic                    card_fire;
  logic                    out_free;
  link_t [NUM_CELLS-1:0]   link;
  digit_t [NUM_CELLS-1:0]  digs;
  digit_t [NUM_CELLS-1:0]  terms;
  class_t                  cls;
  logic                    ok;
  count_t                  cnt;

  assign card_stall = state != ST_IDLE;
  assign card_fire  = card_valid && !card_stall;
  assign out_free   = !result_valid || !result_stall;
  assign link[0]    = sreg[IN_W-1 -: BITS_PER_STEP];

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    if (i == NUM_CELLS - 1) begin : g_last
      lcc_cell u_cell (
        .clk      (clk),
        .clr      (card_fire),
        .step     (state == ST_CONV),
        .bits_in  (link[i]),
        .dbl      (1'(i % 2)),
        .en       (i < MAX_DIGITS),
        .bits_out (),
        .dig      (digs[i]),
        .term     (terms[i])
      );
    end else begin : g_mid
      lcc_cell u_cell (
        .clk      (clk),
        .clr      (card_fire),
        .step     (state == ST_CONV),
        .bits_in  (link[i]),
        .dbl      (1'(i % 2)),
        .en       (i < MAX_DIGITS),
        .bits_out (link[i+1]),
        .dig      (digs[i]),
        .term     (terms[i])
      );
    end
  end

  lcc_fold #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_fold (
    .clk   (clk),
    .load  (state == ST_SUM),
    .digs  (digs),
    .terms (terms),
    .cls   (cls),
    .ok    (ok),
    .cnt   (cnt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == ST_FIN && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (card_fire) begin
            state    <= ST_CONV;
            step_cnt <= '0;
          end
        end
        ST_CONV: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == STEP_W'(NUM_STEPS - 1)) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (card_fire) begin
      sreg <= card_number;
    end else if (state == ST_CONV) begin
      sreg <= {sreg[IN_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      card_class  <= cls;
      luhn_ok     <= ok;
      digit_count <= cnt;
    end
  end

endmodule

FILE: hw/rtl/lcc_chk.sv
// ----------------------------------------------------------------------------
// lcc_chk
// port-level checker for the card number check, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcc_chk import lcc_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            card_valid,
  input logic            card_stall,
  input logic            result_valid,
  input logic            result_stall,
  input class_t          card_class,
  input logic            luhn_ok,
  input count_t          digit_count
);

  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall,
    result_valid && $stable(card_class) && $stable(luhn_ok) && $stable(digit_count),
    "stalled result transaction changed")

  `ASSERT_NEXT(a_busy_after_take, clk, rst, card_valid && !card_stall,
    card_stall, "card transaction taken while not busy")

  `ASSERT_IMPLY(a_class_needs_luhn, clk, rst, result_valid && card_class != CLASS_INVALID,
    luhn_ok, "class reported on a failed luhn sum")

  `ASSERT_IMPLY(a_class_length, clk, rst, result_valid && card_class != CLASS_INVALID,
    digit_count == LEN_THIRTEEN || digit_count == LEN_FIFTEEN
    || digit_count == LEN_SIXTEEN, "class reported with a wrong digit count")

endmodule

bind luhn_card_number_check lcc_chk u_lcc_chk (.*);

FILE: tb/luhn_card_number_check_tb.sv
// ----------------------------------------------------------------------------
// luhn_card_number_check_tb
// self-checking bench for the luhn card number check
//
// Drives card numbers over the valid/stall channel and collects results
// with a randomly stalling receiver. A scoreboard predicts digit count,
// luhn test and prefix class for every accepted number and compares each
// result in order. Most stimulus is well-formed card numbers of every class
// with random digits and a correct check digit, mixed with near misses,
// broken check digits and random numbers of any length.
// ----------------------------------------------------------------------------
module luhn_card_number_check_tb;
  import lcc_pkg::*;

  localparam int CARD_DIGITS = MAX_DIGITS_DEF;
  localparam int RANDOM_PER_PHASE = 567;
  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT = 1000000;
  localparam longint unsigned IN_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [IN_W-1:0] number;
    class_t          card_class;
    logic            luhn_ok;
    count_t          digit_count;
  } card_result_t;

  class card_scoreboard;
    card_result_t expected_q[$];
    int unsigned errors;

    static function card_result_t predict_card(input logic [IN_W-1:0] num,
                                               output int unsigned sum);
      longint unsigned v;
      int unsigned cnt, top, nxt, d, d2, prefix;
      bit over, ok;
      card_result_t r;
      v = {1'b0, num};
      cnt = 0;
      sum = 0;
      top = 0;
      nxt = 0;
      while (v != 0 && cnt < CARD_DIGITS) begin
        d = 32'(v % 10);
        v = v / 10;
        if (cnt % 2 == 1) begin
          d2 = 2 * d;
          sum += d2 / 10 + d2 % 10;
        end else begin
          sum += d;
        end
        nxt = top;
        top = d;
        cnt++;
      end
      over = (v != 0);
      ok = (sum % 10 == 0);
      prefix = (cnt >= 2) ? top * 10 + nxt : top;
      r.number = num;
      r.card_class = CLASS_INVALID;
      r.luhn_ok = ok;
      r.digit_count = count_t'(cnt);
      if (ok && !over) begin
        if ((prefix == 34 || prefix == 37) && cnt == LEN_FIFTEEN) begin
          r.card_class = CLASS_FIFTEEN;
        end else if (prefix >= 51 && prefix <= 55 && cnt == LEN_SIXTEEN) begin
          r.card_class = CLASS_SIXTEEN;
        end else if (top == 4 && (cnt == LEN_THIRTEEN || cnt == LEN_SIXTEEN)) begin
          r.card_class = CLASS_FOUR;
        end
      end
      return r;
    endfunction

    function void note_card(input logic [IN_W-1:0] num);
      int unsigned sum;
      expected_q.push_back(predict_card(num, sum));
    endfunction

    function void check_result(input class_t cls, input logic ok, input count_t cnt);
      card_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result class %0d luhn_ok %0d digit_count %0d",
                 $time, cls, ok, cnt);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (cls !== exp_r.card_class) begin
        $display("%0t: number %0d card_class expected %0d actual %0d",
                 $time, exp_r.number, exp_r.card_class, cls);
        errors++;
      end
      if (ok !== exp_r.luhn_ok) begin
        $display("%0t: number %0d luhn_ok expected %0d actual %0d",
                 $time, exp_r.number, exp_r.luhn_ok, ok);
        errors++;
      end
      if (cnt !== exp_r.digit_count) begin
        $display("%0t: number %0d digit_count expected %0d actual %0d",
                 $time, exp_r.number, exp_r.digit_count, cnt);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            card_valid = 1'b0;
  logic            card_stall;
  logic [IN_W-1:0] card_number = '0;
  logic            result_valid;
  logic            result_stall = 1'b0;
  class_t          card_class;
  logic            luhn_ok;
  count_t          digit_count;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;
  card_scoreboard sb = new();

  luhn_card_number_check #(.MAX_DIGITS(CARD_DIGITS)) dut (
    .clk(clk),
    .rst(rst),
    .card_valid(card_valid),
    .card_stall(card_stall),
    .card_number(card_number),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .card_class(card_class),
    .luhn_ok(luhn_ok),
    .digit_count(digit_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      sb.check_result(card_class, luhn_ok, digit_count);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // random number with exactly n decimal digits, capped at the input range
  function automatic longint unsigned rand_digits(input int unsigned n);
    longint unsigned lo, hi, r;
    int unsigned i;
    lo = 1;
    for (i = 1; i < n; i++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (hi > IN_MAX) hi = IN_MAX;
    r = {$urandom, $urandom};
    return lo + r % (hi - lo + 1);
  endfunction

  // prefix, random middle digits and a check digit that passes the luhn test
  function automatic longint unsigned make_card(input longint unsigned prefix,
                                                input int unsigned pre_len,
                                                input int unsigned len);
    longint unsigned base;
    int unsigned i, sum;
    card_result_t r;
    base = prefix;
    for (i = pre_len; i + 1 < len; i++) base = base * 10 + $urandom_range(0, 9);
    r = card_scoreboard::predict_card(IN_W'(base * 10), sum);
    return base * 10 + (10 - sum % 10) % 10;
  endfunction

  function automatic longint unsigned break_check(input longint unsigned num);
    longint unsigned c;
    c = num % 10;
    return num - c + (c + $urandom_range(1, 9)) % 10;
  endfunction

  function automatic longint unsigned random_card();
    longint unsigned near_pre[8] = '{33, 35, 36, 38, 50, 56, 3, 5};
    longint unsigned num;
    case ($urandom_range(0, 9))
      0, 1: num = make_card($urandom_range(0, 1) ? 37 : 34, 2, 15);
      2, 3: num = make_card($urandom_range(51, 55), 2, 16);
      4, 5: num = make_card(4, 1, $urandom_range(0, 1) ? 16 : 13);
      6: begin
        if ($urandom_range(0, 1)) begin
          num = make_card(near_pre[$urandom_range(0, 7)], 2, $urandom_range(13, 16));
        end else begin
          case ($urandom_range(0, 2))
            0: num = make_card(34 + 3 * $urandom_range(0, 1), 2, $urandom_range(12, 18));
            1: num = make_card($urandom_range(51, 55), 2, $urandom_range(12, 18));
            default: num = make_card(4, 1, $urandom_range(2, 18));
          endcase
        end
      end
      7: begin
        case ($urandom_range(0, 2))
          0: num = make_card($urandom_range(0, 1) ? 37 : 34, 2, 15);
          1: num = make_card($urandom_range(51, 55), 2, 16);
          default: num = make_card(4, 1, $urandom_range(0, 1) ? 16 : 13);
        endcase
        num = break_check(num);
      end
      8: num = rand_digits($urandom_range(1, 19));
      default: num = {$urandom, $urandom} & IN_MAX;
    endcase
    return num;
  endfunction

  task automatic send_card(input longint unsigned num);
    if (card_valid && $urandom_range(0, 99) < send_idle_pct) begin
      card_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    card_valid <= 1'b1;
    card_number <= IN_W'(num);
    @(posedge clk);
    while (card_stall) @(posedge clk);
    sb.note_card(IN_W'(num));
  endtask

  task automatic wait_drained();
    card_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 11;
          stall_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          stall_pct = 11;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
      endcase
      if (phase == 0) begin
        send_card(0);
        send_card(1);
        send_card(9);
        send_card(10);
        send_card(18);
        send_card(99);
        send_card(IN_MAX);
        send_card(64'h4000_0000_0000_0000);
        send_card(64'h2AAA_AAAA_AAAA_AAAA);
        send_card(64'h5555_5555_5555_5555);
        send_card(64'd1000000000000000000);
        send_card(make_card(34, 2, 15));
        send_card(make_card(37, 2, 15));
        send_card(make_card(51, 2, 16));
        send_card(make_card(55, 2, 16));
        send_card(make_card(4, 1, 13));
        send_card(make_card(4, 1, 16));
        send_card(make_card(4, 1, 14));
        send_card(make_card(34, 2, 16));
        send_card(make_card(50, 2, 16));
        send_card(make_card(56, 2, 16));
        send_card(make_card(35, 2, 15));
        send_card(break_check(make_card(37, 2, 15)));
        send_card(break_check(make_card(4, 1, 16)));
      end
      repeat (RANDOM_PER_PHASE) send_card(random_card());
      // hold off until every result of this phase is back
      wait_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
